FILE: sv/hswd_pkg.sv
// Package for the hue/saturation window detector.
// Holds field widths, register codes, reset values and the divider stage record.
// No dependencies.
package hswd_pkg;

  localparam int unsigned PIX_W = 8;    // width of one color component
  localparam int unsigned CFG_IDX_W = 4;  // register index width on the config port
  localparam int unsigned CFG_DAT_W = 8;  // register data width
  localparam int unsigned QUO_W = 9;    // quotient bits produced by the dividers
  localparam int unsigned NUM_W = 18;   // dividend / remainder width
  localparam int unsigned DIV_W = 9;    // divisor width (twice an 8-bit value)

  localparam logic [7:0] MIN_HUE_RST = 8'd160;
  localparam logic [7:0] MAX_HUE_RST = 8'd10;
  localparam logic [7:0] MIN_SAT_RST = 8'd25;
  localparam logic [7:0] MAX_SAT_RST = 8'd166;

  localparam logic [QUO_W-1:0] HUE_WRAP = 9'd180;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_HUE = 4'd0,
    REG_MAX_HUE = 4'd1,
    REG_MIN_SAT = 4'd2,
    REG_MAX_SAT = 4'd3
  } reg_idx_t;

  // One slot of the divider pipeline: both long divisions advance side by side.
  typedef struct packed {
    logic [NUM_W-1:0] rem_h;
    logic [QUO_W-1:0] quo_h;
    logic [DIV_W-1:0] div_h;
    logic [NUM_W-1:0] rem_s;
    logic [QUO_W-1:0] quo_s;
    logic [DIV_W-1:0] div_s;
    logic             grey;
  } div_slot_t;

endpackage

FILE: sv/hswd_pixel_if.sv
// Pixel input channel of the hue/saturation window detector.
// Depends on hswd_pkg for the component width.
interface hswd_pixel_if
  import hswd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

FILE: sv/hswd_mask_if.sv
// Mask result channel of the hue/saturation window detector.
// Self-contained; carries one mask bit per transfer.
interface hswd_mask_if;
  logic valid;
  logic ready;
  logic in_window;

  modport source (output valid, in_window, input ready);
  modport sink (input valid, in_window, output ready);
endinterface

FILE: sv/hswd_cfg_if.sv
// Configuration write channel of the hue/saturation window detector.
// Depends on hswd_pkg for index and data widths.
interface hswd_cfg_if
  import hswd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/hue_saturation_window_detector.sv
// Hue/saturation window detector: BGR pixel in, one mask bit out.
// Each pixel passes the input register, the preparation stage, the divider stages
// and the window tests, whose result is held in the output register.
// Throughput: one pixel per cycle while the mask side is ready (9-stage divider).
// Reset (rst, synchronous) empties the pipeline and loads the default windows.
// Depends on hswd_pkg, hswd_pixel_if, hswd_mask_if and hswd_cfg_if.
module hue_saturation_window_detector
  import hswd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  hswd_pixel_if.sink        pixel,
  hswd_mask_if.source       mask,
  hswd_cfg_if.sink          cfg
);

  // Stage map:
  //   0           input register (blue, green, red)
  //   1           preparation: max, spread, hue and saturation dividends
  //   2 .. 10     one quotient bit of each division per stage, MSB first
  //   11          window tests; this is the output register
  // Each stage holds its data when the stage after it is full and stalled,
  // and fills any bubble ahead of a stall, so nothing is lost or repeated.
  localparam int unsigned NSTG = QUO_W + 3;
  localparam int unsigned LAST = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  // Window registers. Writes are accepted at any time and take effect at once;
  // an index past the last register is ignored.
  logic [7:0] min_hue;
  logic [7:0] max_hue;
  logic [7:0] min_sat;
  logic [7:0] max_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_hue <= MIN_HUE_RST;
      max_hue <= MAX_HUE_RST;
      min_sat <= MIN_SAT_RST;
      max_sat <= MAX_SAT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MIN_HUE: min_hue <= cfg.data;
        REG_MAX_HUE: max_hue <= cfg.data;
        REG_MIN_SAT: min_sat <= cfg.data;
        REG_MAX_SAT: max_sat <= cfg.data;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage can take new data when it is empty or moving on.
  always_comb begin
    rdy[LAST] = !vld[LAST] || mask.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign pixel.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pixel.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic [PIX_W-1:0] b0;
  logic [PIX_W-1:0] g0;
  logic [PIX_W-1:0] r0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      b0 <= pixel.blue;
      g0 <= pixel.green;
      r0 <= pixel.red;
    end
  end

  // Stage 1 logic. V is the largest component and d the spread. The hue
  // dividend is 60*h + 361*d, which is always positive because h >= -d;
  // dividing it by 2d gives the rounded hue plus 180. The saturation
  // dividend 510*d + V over 2V gives round(255*d/V).
  logic [7:0]        vmax;
  logic [7:0]        vmin;
  logic [7:0]        spread;
  logic signed [11:0] h_diff;
  logic signed [19:0] t_hue;
  logic [NUM_W-1:0]  n_sat;
  div_slot_t         prep;

  always_comb begin
    vmax = b0;
    if (g0 > vmax) vmax = g0;
    if (r0 > vmax) vmax = r0;
    vmin = b0;
    if (g0 < vmin) vmin = g0;
    if (r0 < vmin) vmin = r0;
    spread = vmax - vmin;

    if (vmax == r0) begin
      h_diff = 12'(signed'({1'b0, g0})) - 12'(signed'({1'b0, b0}));
    end else if (vmax == g0) begin
      h_diff = 12'(signed'({1'b0, b0})) - 12'(signed'({1'b0, r0}))
             + 12'(signed'({3'b000, spread, 1'b0}));
    end else begin
      h_diff = 12'(signed'({1'b0, r0})) - 12'(signed'({1'b0, g0}))
             + 12'(signed'({2'b00, spread, 2'b00}));
    end

    t_hue = 20'(h_diff) * 20'sd60 + 20'(signed'({1'b0, spread})) * 20'sd361;
    n_sat = NUM_W'({1'b0, spread} * 18'd510) + NUM_W'(vmax);

    prep.rem_h = t_hue[NUM_W-1:0];
    prep.quo_h = '0;
    prep.div_h = {spread, 1'b0};
    prep.rem_s = n_sat;
    prep.quo_s = '0;
    prep.div_s = {vmax, 1'b0};
    prep.grey  = (spread == 8'd0);
  end

  // Divider pipeline. slot[0] is stage 1; slot[k] is stage k+1 and has
  // resolved quotient bit QUO_W-k. Grey pixels carry a zero hue divisor and
  // their quotients are discarded at the end.
  div_slot_t slot [QUO_W+1];
  div_slot_t slot_next [QUO_W+1];

  always_comb begin
    logic [NUM_W-1:0] sh_h;
    logic [NUM_W-1:0] sh_s;
    slot_next[0] = prep;
    for (int k = 1; k <= QUO_W; k++) begin
      slot_next[k] = slot[k-1];
      sh_h = NUM_W'(slot[k-1].div_h) << (QUO_W - k);
      sh_s = NUM_W'(slot[k-1].div_s) << (QUO_W - k);
      if (slot[k-1].rem_h >= sh_h) begin
        slot_next[k].rem_h = slot[k-1].rem_h - sh_h;
        slot_next[k].quo_h[QUO_W-k] = 1'b1;
      end
      if (slot[k-1].rem_s >= sh_s) begin
        slot_next[k].rem_s = slot[k-1].rem_s - sh_s;
        slot_next[k].quo_s[QUO_W-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QUO_W; k++) begin
      if (rdy[k+1]) begin
        slot[k] <= slot_next[k];
      end
    end
  end

  // Final stage: fold the hue quotient back into 0..179, then test both
  // windows. The hue window wraps around when its lower bound is not below
  // its upper bound.
  logic [QUO_W-1:0] q_hue;
  logic [7:0]       hue;
  logic [7:0]       sat;
  logic             hue_ok;
  logic             sat_ok;
  logic             in_window;

  always_comb begin
    q_hue = slot[QUO_W].quo_h;
    if (slot[QUO_W].grey) begin
      hue = 8'd0;
      sat = 8'd0;
    end else begin
      hue = (q_hue >= HUE_WRAP) ? 8'(q_hue - HUE_WRAP) : q_hue[7:0];
      sat = slot[QUO_W].quo_s[7:0];
    end
    if (min_hue < max_hue) begin
      hue_ok = (hue > min_hue) && (hue <= max_hue);
    end else begin
      hue_ok = (hue > min_hue) || (hue <= max_hue);
    end
    sat_ok = (sat > min_sat) && (sat <= max_sat);
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      in_window <= hue_ok && sat_ok;
    end
  end

  assign mask.valid     = vld[LAST];
  assign mask.in_window = in_window;

endmodule

FILE: verif/hue_saturation_window_detector_tb.sv
// Self-checking testbench for the hue/saturation window detector.
// Drives BGR pixels and window settings, and checks each mask bit against a local predictor.
// Depends on hswd_pkg, the three channel interfaces and hue_saturation_window_detector.
module hue_saturation_window_detector_tb;
  import hswd_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int REG_COUNT = 4;          // registers behind the config port
  localparam int PHASES = 8;             // window settings exercised by the random part
  localparam int PIXELS_PER_PHASE = 116;
  localparam int DRAIN_CYCLES = 24;      // more than the depth of the pipeline
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int MAX_WAIT = 13;          // longest idle gap or stall drawn per item
  localparam int DIRECTED_ROWS = 22;
  localparam int FIXED_SETS = 6;

  typedef enum logic {ROW_PREDICT, ROW_KNOWN} row_kind_t;

  // One row of the directed table. The mask bit is only meaningful on known rows.
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    row_kind_t        kind;
    logic             in_window;
  } pixel_row_t;

  // A full set of window bounds, written together between phases.
  typedef struct packed {
    logic [CFG_DAT_W-1:0] hue_lo;
    logic [CFG_DAT_W-1:0] hue_hi;
    logic [CFG_DAT_W-1:0] sat_lo;
    logic [CFG_DAT_W-1:0] sat_hi;
  } window_set_t;

  // A mask bit still owed by the block, with its pixel kept for the error line.
  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             in_window;
  } mask_due_t;

  logic clk = 1'b0;
  logic rst;

  hswd_pixel_if pixel_ch ();
  hswd_mask_if  mask_ch ();
  hswd_cfg_if   cfg_ch ();

  hue_saturation_window_detector uut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .mask  (mask_ch),
    .cfg   (cfg_ch)
  );

  always #4 clk = ~clk;

  // The predictor's own copy of the four window bounds.
  logic [CFG_DAT_W-1:0] window_bound [REG_COUNT];

  mask_due_t pending_masks [$];
  int        error_count = 0;
  int        idle_cycles = 0;

  // Idle pattern state for each side: a stretch is either steady (no gaps) or gappy.
  int src_left = 0;
  bit src_steady = 1'b0;
  int snk_left = 0;
  bit snk_steady = 1'b0;

  // The directed part runs under the reset windows: hue wraps (above 160 or at most 10),
  // saturation must be above 25 and at most 166. Grey pixels and fully saturated
  // primaries therefore fail the saturation test, which makes their mask easy to read off.
  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   ROW_KNOWN,   1'b0},  // black: value zero, grey
    '{8'd255, 8'd255, 8'd255, ROW_KNOWN,   1'b0},  // white: grey
    '{8'd128, 8'd128, 8'd128, ROW_KNOWN,   1'b0},  // mid grey
    '{8'd0,   8'd0,   8'd255, ROW_KNOWN,   1'b0},  // pure red, saturation 255
    '{8'd0,   8'd255, 8'd0,   ROW_KNOWN,   1'b0},  // pure green
    '{8'd255, 8'd0,   8'd0,   ROW_KNOWN,   1'b0},  // pure blue
    '{8'd255, 8'd255, 8'd0,   ROW_PREDICT, 1'b0},  // cyan
    '{8'd0,   8'd255, 8'd255, ROW_PREDICT, 1'b0},  // yellow
    '{8'd255, 8'd0,   8'd255, ROW_PREDICT, 1'b0},  // magenta
    '{8'd140, 8'd160, 8'd210, ROW_PREDICT, 1'b0},  // skin tone, hue just under the top
    '{8'd150, 8'd140, 8'd210, ROW_PREDICT, 1'b0},  // red sector, negative hue wraps up
    '{8'd120, 8'd150, 8'd200, ROW_PREDICT, 1'b0},  // skin tone, hue just past the top
    '{8'd1,   8'd0,   8'd255, ROW_PREDICT, 1'b0},  // tiny negative hue rounds to zero
    '{8'd0,   8'd1,   8'd1,   ROW_PREDICT, 1'b0},  // smallest nonzero spread
    '{8'd254, 8'd255, 8'd255, ROW_PREDICT, 1'b0},  // near white
    '{8'd0,   8'd128, 8'd255, ROW_PREDICT, 1'b0},  // orange
    '{8'd255, 8'd128, 8'd0,   ROW_PREDICT, 1'b0},  // blue sector
    '{8'd0,   8'd255, 8'd128, ROW_PREDICT, 1'b0},  // green sector
    '{8'd128, 8'd0,   8'd255, ROW_PREDICT, 1'b0},  // red sector, blue above green
    '{8'd1,   8'd1,   8'd2,   ROW_PREDICT, 1'b0},  // dark, rounding of saturation
    '{8'd200, 8'd100, 8'd100, ROW_PREDICT, 1'b0},  // blue maximum, green equals red
    '{8'd100, 8'd200, 8'd100, ROW_PREDICT, 1'b0}   // green maximum
  };

  // Extremes first: the widest plain windows, hue 0 alone with no saturation, a wrap
  // covering every hue, a degenerate window, two realistic skin windows (plain, wrapping).
  window_set_t window_sets [FIXED_SETS] = '{
    '{8'd0,   8'd180, 8'd0,   8'd255},
    '{8'd180, 8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd0,   8'd255},
    '{8'd90,  8'd90,  8'd128, 8'd128},
    '{8'd5,   8'd25,  8'd40,  8'd200},
    '{8'd170, 8'd20,  8'd20,  8'd180}
  };

  // Converts one BGR pixel to hue and saturation and applies both windows.
  // The hue is rounded half up in half-degree units; a grey pixel has hue and
  // saturation zero. The hue window wraps when its lower bound is not below the upper.
  function automatic logic predict_in_window(input logic [PIX_W-1:0] b, g, r);
    int  bi, gi, ri, v, mn, d, h, hue, sat;
    int  hue_lo, hue_hi, sat_lo, sat_hi;
    logic hue_hit, sat_hit;
    bi = b;
    gi = g;
    ri = r;
    v = bi;
    mn = bi;
    if (gi > v) v = gi;
    if (ri > v) v = ri;
    if (gi < mn) mn = gi;
    if (ri < mn) mn = ri;
    d = v - mn;
    if (d == 0) begin
      hue = 0;
    end else begin
      if (v == ri) h = gi - bi;
      else if (v == gi) h = bi - ri + 2 * d;
      else h = ri - gi + 4 * d;
      // The 360*d offset keeps the dividend positive, so truncation is a floor.
      hue = (60 * h + d + 360 * d) / (2 * d) - 180;
      if (hue < 0) hue += 180;
      if (hue >= 180) hue -= 180;
    end
    sat = (v == 0) ? 0 : (2 * 255 * d + v) / (2 * v);
    hue_lo = window_bound[REG_MIN_HUE];
    hue_hi = window_bound[REG_MAX_HUE];
    sat_lo = window_bound[REG_MIN_SAT];
    sat_hi = window_bound[REG_MAX_SAT];
    if (hue_lo < hue_hi) hue_hit = (hue > hue_lo) && (hue <= hue_hi);
    else hue_hit = (hue > hue_lo) || (hue <= hue_hi);
    sat_hit = (sat > sat_lo) && (sat <= sat_hi);
    return hue_hit && sat_hit;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    error_count++;
  endtask

  // Draws the idle cycles before the next transfer on one side. Stretches of
  // 20 to 60 items are either steady or gappy.
  task automatic draw_wait(inout int left, inout bit steady, output int cycles);
    if (left == 0) begin
      steady = ($urandom_range(0, 3) == 0);
      left = $urandom_range(20, 60);
    end
    left--;
    cycles = steady ? 0 : $urandom_range(0, MAX_WAIT);
  endtask

  // Offers one pixel and returns once it is accepted. Valid stays high afterwards,
  // so a pixel with no gap follows in the very next cycle.
  task automatic send_pixel(input logic [PIX_W-1:0] b, g, r, input row_kind_t kind,
                            input logic typed_bit);
    int        gap;
    mask_due_t due;
    draw_wait(src_left, src_steady, gap);
    @(negedge clk);
    if (gap != 0) begin
      pixel_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid = 1'b1;
    pixel_ch.blue = b;
    pixel_ch.green = g;
    pixel_ch.red = r;
    do @(posedge clk); while (!pixel_ch.ready);
    due.blue = b;
    due.green = g;
    due.red = r;
    due.in_window = (kind == ROW_KNOWN) ? typed_bit : predict_in_window(b, g, r);
    pending_masks.push_back(due);
  endtask

  task automatic release_pixel();
    @(negedge clk);
    pixel_ch.valid = 1'b0;
  endtask

  // Waits until every mask bit owed has come out of the block.
  task automatic wait_drained();
    while (pending_masks.size() != 0) @(posedge clk);
  endtask

  // One config transfer. Indexes past the register list must leave every bound alone.
  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < REG_COUNT) window_bound[idx] = value;
  endtask

  // Writes all four bounds in a shuffled order, with up to two stray writes to
  // unused indexes mixed in.
  task automatic program_windows(input window_set_t ws);
    logic [CFG_DAT_W-1:0] value [REG_COUNT];
    reg_idx_t             order [REG_COUNT];
    reg_idx_t             tmp;
    int                   junk, j;
    value[REG_MIN_HUE] = ws.hue_lo;
    value[REG_MAX_HUE] = ws.hue_hi;
    value[REG_MIN_SAT] = ws.sat_lo;
    value[REG_MAX_SAT] = ws.sat_hi;
    order = '{REG_MIN_HUE, REG_MAX_HUE, REG_MIN_SAT, REG_MAX_SAT};
    for (int k = REG_COUNT - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    junk = $urandom_range(0, 2);
    foreach (order[k]) begin
      if (junk != 0 && $urandom_range(0, 1) == 1) begin
        write_bound(CFG_IDX_W'($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1)),
                    CFG_DAT_W'($urandom_range(0, 255)));
        junk--;
      end
      write_bound(order[k], value[order[k]]);
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] jitter(input int base);
    int c;
    c = base + $urandom_range(0, 6) - 3;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] corner_byte();
    return $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1)) : 8'($urandom_range(0, 1));
  endfunction

  // Random pixels: half uniform, the rest greys, corner values, near-greys with a
  // spread of a few codes, and very dark pixels where rounding matters most.
  task automatic random_pixel(output logic [PIX_W-1:0] b, g, r);
    int base;
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        b = PIX_W'($urandom_range(0, 255));
        g = PIX_W'($urandom_range(0, 255));
        r = PIX_W'($urandom_range(0, 255));
      end
      5: begin
        b = PIX_W'(base);
        g = PIX_W'(base);
        r = PIX_W'(base);
      end
      6, 7: begin
        b = corner_byte();
        g = corner_byte();
        r = corner_byte();
      end
      8: begin
        b = jitter(base);
        g = jitter(base);
        r = jitter(base);
      end
      default: begin
        b = PIX_W'($urandom_range(0, 7));
        g = PIX_W'($urandom_range(0, 7));
        r = PIX_W'($urandom_range(0, 7));
      end
    endcase
  endtask

  // Random windows for the last phases. The saturation window is usually well
  // formed, so the mask is set often enough to matter.
  function automatic window_set_t random_windows();
    window_set_t ws;
    ws.hue_lo = CFG_DAT_W'($urandom_range(0, 180));
    ws.hue_hi = CFG_DAT_W'($urandom_range(0, 180));
    ws.sat_lo = CFG_DAT_W'($urandom_range(0, 200));
    ws.sat_hi = CFG_DAT_W'($urandom_range(ws.sat_lo, 255));
    return ws;
  endfunction

  // Result side: each mask transfer is checked against the oldest pixel still owed.
  initial begin : mask_sink
    int        stall;
    mask_due_t due;
    mask_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      draw_wait(snk_left, snk_steady, stall);
      @(negedge clk);
      if (stall != 0) begin
        mask_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      mask_ch.ready = 1'b1;
      do @(posedge clk); while (!mask_ch.valid);
      if (pending_masks.size() == 0) begin
        report_mismatch($sformatf("mask %0b arrived with no pixel pending",
                                  mask_ch.in_window));
      end else begin
        due = pending_masks.pop_front();
        if (mask_ch.in_window !== due.in_window)
          report_mismatch($sformatf("pixel b=%0d g=%0d r=%0d: in_window %0b, predicted %0b",
                                    due.blue, due.green, due.red, mask_ch.in_window,
                                    due.in_window));
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (mask_ch.valid && mask_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ERROR no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("hue_saturation_window_detector: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] b, g, r;
    window_set_t      ws;
    rst = 1'b1;
    pixel_ch.valid = 1'b0;
    pixel_ch.blue = '0;
    pixel_ch.green = '0;
    pixel_ch.red = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    window_bound[REG_MIN_HUE] = MIN_HUE_RST;
    window_bound[REG_MAX_HUE] = MAX_HUE_RST;
    window_bound[REG_MIN_SAT] = MIN_SAT_RST;
    window_bound[REG_MAX_SAT] = MAX_SAT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows under the reset windows.
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red,
                 directed_rows[i].kind, directed_rows[i].in_window);

    // Each phase waits for the pipeline to empty, loads new windows, then streams
    // random pixels through them.
    for (int phase = 0; phase < PHASES; phase++) begin
      release_pixel();
      wait_drained();
      ws = (phase < FIXED_SETS) ? window_sets[phase] : random_windows();
      program_windows(ws);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        random_pixel(b, g, r);
        send_pixel(b, g, r, ROW_PREDICT, 1'b0);
      end
    end

    release_pixel();
    wait_drained();
    // Extra cycles catch any mask bit the block emits beyond those owed.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("hue_saturation_window_detector: match");
    else
      $display("hue_saturation_window_detector: mismatch");
    $finish;
  end

endmodule
